@@ hdl/rfr_pkg.sv @@
// Shared types, constants and reset values for the reply frame receiver.
package rfr_pkg;

  // Frame layout
  localparam int unsigned FRAME_BODY_BYTES_DEF = 8;
  localparam int unsigned CMD_POS              = 3;
  localparam int unsigned VAL_POS_FIRST        = 4;
  localparam int unsigned VAL_BYTES            = 4;
  localparam logic [7:0]  POSITION_CMD         = 8'd6;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_ADDR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULE_ADDR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUCCESS_STAT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_PRD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 3'd4;

  // Configuration reset values
  localparam logic [7:0]  RST_REPLY_ADDR    = 8'd2;
  localparam logic [7:0]  RST_MODULE_ADDR   = 8'd1;
  localparam logic [7:0]  RST_SUCCESS_STAT  = 8'h64;
  localparam logic [15:0] RST_TICKS_PER_PRD = 16'd1000;
  localparam logic [3:0]  RST_TIMEOUT_LIMIT = 4'd3;

  // Input item kinds
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Frame status codes
  localparam logic [1:0] FS_NONE   = 2'd0;
  localparam logic [1:0] FS_GOOD   = 2'd1;
  localparam logic [1:0] FS_CKSUM  = 2'd2;

  typedef struct packed {
    logic [7:0]  reply_address;
    logic [7:0]  module_address;
    logic [7:0]  success_status;
    logic [15:0] ticks_per_period;
    logic [3:0]  timeout_limit;
  } cfg_t;

  // Frame outcome of one byte beat
  typedef struct packed {
    logic [1:0]         frame_status;
    logic [7:0]         command_code;
    logic signed [31:0] reply_value;
    logic               is_position_reply;
  } frame_res_t;

  // Link timeout view after one beat
  typedef struct packed {
    logic [3:0] timeout_count;
    logic       timeout_alarm;
  } tmo_res_t;

  typedef struct packed {
    frame_res_t frame;
    tmo_res_t   tmo;
  } result_t;

endpackage

@@ hdl/rfr_ifs.sv @@
// Valid/ready channel interfaces: input items, results and configuration writes.
interface rfr_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;
  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface rfr_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         frame_status;
  logic [7:0]         command_code;
  logic signed [31:0] reply_value;
  logic               is_position_reply;
  logic [3:0]         timeout_count;
  logic               timeout_alarm;
  modport source (output valid, output frame_status, output command_code,
                  output reply_value, output is_position_reply,
                  output timeout_count, output timeout_alarm, input ready);
  modport sink   (input valid, input frame_status, input command_code,
                  input reply_value, input is_position_reply,
                  input timeout_count, input timeout_alarm, output ready);
endinterface

interface rfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/rfr_cfg_regs.sv @@
// Configuration register file written over the cfg channel.
module rfr_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  rfr_cfg_if.sink        cfg_bus,
  output rfr_pkg::cfg_t  cfg
);
  import rfr_pkg::*;

  cfg_t cfg_r;

  // always able to take a write beat
  assign cfg_bus.ready = 1'b1;
  assign cfg           = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reply_address    <= RST_REPLY_ADDR;
      cfg_r.module_address   <= RST_MODULE_ADDR;
      cfg_r.success_status   <= RST_SUCCESS_STAT;
      cfg_r.ticks_per_period <= RST_TICKS_PER_PRD;
      cfg_r.timeout_limit    <= RST_TIMEOUT_LIMIT;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        CFG_REPLY_ADDR:    cfg_r.reply_address    <= cfg_bus.data[7:0];
        CFG_MODULE_ADDR:   cfg_r.module_address   <= cfg_bus.data[7:0];
        CFG_SUCCESS_STAT:  cfg_r.success_status   <= cfg_bus.data[7:0];
        CFG_TICKS_PER_PRD: cfg_r.ticks_per_period <= cfg_bus.data;
        CFG_TIMEOUT_LIMIT: cfg_r.timeout_limit    <= cfg_bus.data[3:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/rfr_parser.sv @@
// Header hunt state machine, body capture and running checksum.
module rfr_parser #(
  parameter int unsigned FRAME_BODY_BYTES = rfr_pkg::FRAME_BODY_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_en,
  input  logic [7:0]          rx_byte,
  input  rfr_pkg::cfg_t       cfg,
  output rfr_pkg::frame_res_t frame,
  output logic                good_frame
);
  import rfr_pkg::*;

  localparam int unsigned IW = $clog2(FRAME_BODY_BYTES + 1);

  typedef enum logic [2:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    HUNT_THIRD,
    HUNT_BODY,
    HUNT_CHECK
  } hunt_t;

  hunt_t             state_r, state_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [7:0]        cmd_r, cmd_nxt;
  logic [31:0]       val_r, val_nxt;
  logic              store_en;
  logic [IW-1:0]     store_pos;
  logic [IW-1:0]     idx_inc;
  logic [31:0]       val_masked;

  assign idx_inc = idx_r + IW'(1);

  // value lanes beyond the body length read as zero
  always_comb begin
    val_masked = '0;
    for (int k = 0; k < VAL_BYTES; k++) begin
      if (VAL_POS_FIRST + k < FRAME_BODY_BYTES) begin
        val_masked[8*(VAL_BYTES-1-k) +: 8] = val_r[8*(VAL_BYTES-1-k) +: 8];
      end
    end
  end

  // next state and frame outcome for one byte beat
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    sum_nxt    = sum_r;
    cmd_nxt    = cmd_r;
    val_nxt    = val_r;
    store_en   = 1'b0;
    store_pos  = idx_r;
    good_frame = 1'b0;
    frame      = '0;
    if (byte_en) begin
      unique case (state_r)
        HUNT_SECOND: begin
          if (rx_byte == cfg.module_address) begin
            store_en  = 1'b1;
            state_nxt = HUNT_THIRD;
          end else begin
            state_nxt = HUNT_FIRST;
          end
        end
        HUNT_THIRD: begin
          if (rx_byte == cfg.success_status) begin
            store_en  = 1'b1;
            state_nxt = HUNT_BODY;
          end else begin
            state_nxt = HUNT_FIRST;
          end
        end
        HUNT_BODY: begin
          store_en = 1'b1;
          if (32'(idx_inc) >= FRAME_BODY_BYTES) begin
            state_nxt = HUNT_CHECK;
          end
        end
        HUNT_CHECK: begin
          if (sum_r == rx_byte) begin
            good_frame                 = 1'b1;
            frame.frame_status         = FS_GOOD;
            frame.command_code         = cmd_r;
            frame.reply_value          = val_masked;
            frame.is_position_reply    = (cmd_r == POSITION_CMD);
          end else begin
            frame.frame_status = FS_CKSUM;
          end
          idx_nxt   = '0;
          state_nxt = HUNT_FIRST;
        end
        default: begin
          idx_nxt   = '0;
          store_pos = '0;
          state_nxt = HUNT_FIRST;
          if (rx_byte == cfg.reply_address) begin
            store_en  = 1'b1;
            state_nxt = HUNT_SECOND;
          end
        end
      endcase
    end
    // body byte store: running sum and the command / value lanes
    if (store_en) begin
      idx_nxt = store_pos + IW'(1);
      sum_nxt = ((store_pos == '0) ? 8'd0 : sum_r) + rx_byte;
      if (store_pos == IW'(CMD_POS)) begin
        cmd_nxt = rx_byte;
      end
      for (int k = 0; k < VAL_BYTES; k++) begin
        if (VAL_POS_FIRST + k < FRAME_BODY_BYTES) begin
          if (store_pos == IW'(VAL_POS_FIRST + k)) begin
            val_nxt[8*(VAL_BYTES-1-k) +: 8] = rx_byte;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= HUNT_FIRST;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // frame payload, no reset needed
  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    cmd_r <= cmd_nxt;
    val_r <= val_nxt;
  end

endmodule

@@ hdl/rfr_timeout.sv @@
// Tick period counter and saturating link timeout count.
module rfr_timeout (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tick_en,
  input  logic              clear,
  input  rfr_pkg::cfg_t     cfg,
  output rfr_pkg::tmo_res_t tmo
);
  import rfr_pkg::*;

  logic [15:0] tick_r, tick_nxt;
  logic [3:0]  missed_r, missed_nxt;
  logic [15:0] tick_inc;
  logic [4:0]  missed_inc;

  assign tick_inc   = tick_r + 16'd1;
  assign missed_inc = {1'b0, missed_r} + 5'd1;

  always_comb begin
    tick_nxt          = tick_r;
    missed_nxt        = missed_r;
    tmo.timeout_alarm = 1'b0;
    if (tick_en) begin
      tick_nxt = tick_inc;
      // period elapsed: bump the count, clip at the limit
      if (tick_inc >= cfg.ticks_per_period) begin
        tick_nxt = '0;
        if (missed_inc > {1'b0, cfg.timeout_limit}) begin
          missed_nxt        = cfg.timeout_limit;
          tmo.timeout_alarm = 1'b1;
        end else begin
          missed_nxt = missed_inc[3:0];
        end
      end
    end else if (clear) begin
      missed_nxt = '0;
    end
    tmo.timeout_count = missed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r   <= '0;
      missed_r <= '0;
    end else begin
      tick_r   <= tick_nxt;
      missed_r <= missed_nxt;
    end
  end

endmodule

@@ hdl/rfr_out_buf.sv @@
// Two-entry result buffer; input ready comes from registered occupancy only.
module rfr_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  rfr_pkg::result_t wr_data,
  output logic             not_full,
  output logic             rd_valid,
  input  logic             rd_ready,
  output rfr_pkg::result_t rd_data
);
  import rfr_pkg::*;

  result_t    mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       rd_en;

  assign not_full = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_en    = rd_valid && rd_ready;
  assign rd_data  = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= ~wr_ptr_r;
      if (rd_en) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

@@ hdl/reply_frame_receiver_with_timeout.sv @@
// Top level: reply frame receiver with link timeout count.
//
//  channel  | dir | payload                                           | beat when
//  ---------+-----+---------------------------------------------------+-------------------
//  in_bus   | in  | mode, rx_byte                                     | valid && ready
//  out_bus  | out | frame_status, command_code, reply_value,          | valid && ready
//           |     | is_position_reply, timeout_count, timeout_alarm   |
//  cfg_bus  | in  | index, data                                       | valid (ready = 1)
//
// One item per clock while in_bus.ready is high: the hunt machine and timeout counter update in the cycle
// an item is accepted, and its result lands in a two-entry output buffer.
// Each result is registered in the output buffer before it reaches out_bus.
// in_bus.ready drops only when both buffer entries hold untaken results.
// Synchronous active-low reset; no clearing pass, usable the cycle after reset.
module reply_frame_receiver_with_timeout #(
  parameter int unsigned FRAME_BODY_BYTES = rfr_pkg::FRAME_BODY_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rfr_in_if.sink     in_bus,
  rfr_out_if.source  out_bus,
  rfr_cfg_if.sink    cfg_bus
);
  import rfr_pkg::*;

  cfg_t       cfg;
  frame_res_t frame;
  tmo_res_t   tmo;
  result_t    res, head;
  logic       in_acc;
  logic       good_frame;
  logic       not_full;

  assign in_bus.ready = not_full;
  assign in_acc       = in_bus.valid && not_full;

  rfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .cfg     (cfg)
  );

  rfr_parser #(
    .FRAME_BODY_BYTES (FRAME_BODY_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_en    (in_acc && (in_bus.mode == MODE_BYTE)),
    .rx_byte    (in_bus.rx_byte),
    .cfg        (cfg),
    .frame      (frame),
    .good_frame (good_frame)
  );

  rfr_timeout u_tmo (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick_en (in_acc && (in_bus.mode == MODE_TICK)),
    .clear   (good_frame),
    .cfg     (cfg),
    .tmo     (tmo)
  );

  assign res.frame = frame;
  assign res.tmo   = tmo;

  rfr_out_buf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_acc),
    .wr_data  (res),
    .not_full (not_full),
    .rd_valid (out_bus.valid),
    .rd_ready (out_bus.ready),
    .rd_data  (head)
  );

  // result fields from the buffer head
  assign out_bus.frame_status      = head.frame.frame_status;
  assign out_bus.command_code      = head.frame.command_code;
  assign out_bus.reply_value       = head.frame.reply_value;
  assign out_bus.is_position_reply = head.frame.is_position_reply;
  assign out_bus.timeout_count     = head.tmo.timeout_count;
  assign out_bus.timeout_alarm     = head.tmo.timeout_alarm;

endmodule
